>>> src/png_unf_pkg.sv
// ---------------------------------------------------------------------------
// png_unf_pkg: shared types and constants
// Word layouts between the front end, the queues and the reconstruction back
// end, plus filter codes, register indexes and the bit flip helper.
// ---------------------------------------------------------------------------
package png_unf_pkg;

    localparam int DIM_W   = 11;
    localparam int CFG_IDX_W = 1;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // row filter codes
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;
    localparam logic [7:0] FILT_LAST  = 8'd4;

    // word from front end to back end (column index travels alongside)
    typedef struct packed {
        logic       bad;
        logic [7:0] data;
        logic [2:0] filter;
        logic       row_start;
        logic       first_row;
        logic       row_end;
        logic       image_end;
        logic [2:0] tail;
    } mid_word_t;

    // result word
    typedef struct packed {
        logic [7:0] bitmap;
        logic       last_row;
        logic       last_image;
        logic       bad;
    } out_word_t;

    function automatic logic [7:0] flip_byte(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
        begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

>>> src/png_unf_fifo.sv
// ---------------------------------------------------------------------------
// png_unf_fifo: small register queue
// Flop-based FIFO with full/empty flags; read data comes straight from the
// entry at the read pointer.
// ---------------------------------------------------------------------------
module png_unf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/png_unf_front.sv
// ---------------------------------------------------------------------------
// png_unf_front: byte classifier
// Tracks filter byte / data byte position, row and column counters, halts on
// a bad filter byte, and emits one work word per byte that yields a result.
// ---------------------------------------------------------------------------
module png_unf_front #(
    parameter int MAX_DIMENSION = 1024,
    parameter int ROW_DEPTH = 128,
    parameter int COL_W = 7,
    parameter int ADDR_W = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [7:0]                    data_byte,
    input  logic                          first_of_image,
    input  logic [png_unf_pkg::DIM_W-1:0] image_width,
    input  logic [png_unf_pkg::DIM_W-1:0] image_height,
    output logic                          emit,
    output png_unf_pkg::mid_word_t        emit_word,
    output logic [ADDR_W-1:0]             emit_col
);
    import png_unf_pkg::*;

    logic             expect_reg, expect_next;
    logic             halted_reg, halted_next;
    logic             row_start_reg, row_start_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [2:0]       filter_reg, filter_next;

    logic [DIM_W-1:0] width_c, height_c;
    logic [DIM_W+1:0] width_ext;
    logic [COL_W:0]   bytes_per_row;
    logic [COL_W-1:0] col_e;
    logic [DIM_W:0]   row_inc;

    // effective state after an image restart
    logic             exp_s, halt_s, rs_s;
    logic [DIM_W-1:0] row_s;
    logic [COL_W-1:0] col_s;
    logic [2:0]       filt_s;

    always_comb
    begin
        width_c = image_width;
        if (image_width == '0)
        begin
            width_c = DIM_W'(1);
        end
        else if (32'(image_width) > MAX_DIMENSION)
        begin
            width_c = DIM_W'(MAX_DIMENSION);
        end
        height_c = image_height;
        if (image_height == '0)
        begin
            height_c = DIM_W'(1);
        end
        else if (32'(image_height) > MAX_DIMENSION)
        begin
            height_c = DIM_W'(MAX_DIMENSION);
        end
    end

    assign width_ext     = {2'b00, width_c} + (DIM_W+2)'(7);
    assign bytes_per_row = (COL_W+1)'(width_ext >> 3);

    always_comb
    begin
        exp_s  = expect_reg;
        halt_s = halted_reg;
        rs_s   = row_start_reg;
        row_s  = row_reg;
        col_s  = col_reg;
        filt_s = filter_reg;
        if (first_of_image)
        begin
            exp_s  = 1'b1;
            halt_s = 1'b0;
            rs_s   = 1'b0;
            row_s  = '0;
            col_s  = '0;
            filt_s = FILT_NONE;
        end

        // column clamp, only matters if the width shrank mid-image
        col_e = ({1'b0, col_s} >= bytes_per_row) ? COL_W'(bytes_per_row - 1'b1) : col_s;
        row_inc = {1'b0, row_s} + 1'b1;

        expect_next    = exp_s;
        halted_next    = halt_s;
        row_start_next = rs_s;
        row_next       = row_s;
        col_next       = col_s;
        filter_next    = filt_s;

        emit                = 1'b0;
        emit_word           = '0;
        emit_word.data      = data_byte;
        emit_word.filter    = filt_s;
        emit_word.row_start = rs_s;
        emit_word.first_row = (row_s == '0);
        emit_word.tail      = width_c[2:0];
        // a row byte past the end of the row memory shares entry 0
        emit_col            = ({1'b0, col_e} >= (COL_W+1)'(ROW_DEPTH)) ? '0
                                                                     : ADDR_W'(col_e);

        if (halt_s || (row_s >= height_c))
        begin
            emit = 1'b0;
        end
        else if (exp_s)
        begin
            if (data_byte > FILT_LAST)
            begin
                halted_next    = 1'b1;
                emit           = 1'b1;
                emit_word      = '0;
                emit_word.bad  = 1'b1;
            end
            else
            begin
                filter_next    = data_byte[2:0];
                expect_next    = 1'b0;
                row_start_next = 1'b1;
                col_next       = '0;
            end
        end
        else
        begin
            emit           = 1'b1;
            row_start_next = 1'b0;
            if ({1'b0, col_e} == bytes_per_row - 1'b1)
            begin
                emit_word.row_end   = 1'b1;
                emit_word.image_end = (row_inc >= {1'b0, height_c});
                row_next            = DIM_W'(row_inc);
                expect_next         = 1'b1;
                col_next            = '0;
            end
            else
            begin
                col_next = col_e + 1'b1;
            end
        end
        if (!accept)
        begin
            emit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_reg    <= 1'b1;
            halted_reg    <= 1'b0;
            row_start_reg <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            filter_reg    <= FILT_NONE;
        end
        else if (accept)
        begin
            expect_reg    <= expect_next;
            halted_reg    <= halted_next;
            row_start_reg <= row_start_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            filter_reg    <= filter_next;
        end
    end

endmodule

>>> src/png_unf_back.sv
// ---------------------------------------------------------------------------
// png_unf_back: scanline reconstruction
// Reads the byte above from the previous-row memory, applies the row filter
// and writes the rebuilt byte back; formats the bitmap result word.
// ---------------------------------------------------------------------------
module png_unf_back #(
    parameter int ROW_DEPTH = 128,
    parameter int COL_W = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_empty,
    input  png_unf_pkg::mid_word_t in_word,
    input  logic [COL_W-1:0]       in_col,
    output logic                   in_pop,
    input  logic                   out_full,
    output logic                   out_push,
    output png_unf_pkg::out_word_t out_word
);
    import png_unf_pkg::*;

    logic [7:0]       row_mem [ROW_DEPTH];
    logic [7:0]       rdata_reg;
    logic             s1_valid_reg, s1_valid_next;
    mid_word_t        s1_word_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             byp_reg, byp_next;
    logic [7:0]       left_reg, upleft_reg;

    logic             fire, load, wr_mem;
    logic [7:0]       a, b, c, pred, recon, flipped, tmask;
    logic [8:0]       avg_sum;
    logic signed [9:0] pa, pb, pc;

    assign fire   = s1_valid_reg && !out_full;
    assign load   = !in_empty && (!s1_valid_reg || fire);
    assign in_pop = load;
    assign wr_mem = fire && !s1_word_reg.bad;
    assign s1_valid_next = load ? 1'b1 : (fire ? 1'b0 : s1_valid_reg);
    // same column written this cycle: take it from the left register next cycle
    assign byp_next = wr_mem && (s1_col_reg == in_col);

    always_comb
    begin
        a = s1_word_reg.row_start ? 8'h00 : left_reg;
        c = s1_word_reg.row_start ? 8'h00 : upleft_reg;
        b = s1_word_reg.first_row ? 8'h00 : (byp_reg ? left_reg : rdata_reg);

        avg_sum = {1'b0, a} + {1'b0, b};
        pa = ($signed({2'b00, b}) >= $signed({2'b00, c})) ?
             $signed({2'b00, b}) - $signed({2'b00, c}) :
             $signed({2'b00, c}) - $signed({2'b00, b});
        pb = ($signed({2'b00, a}) >= $signed({2'b00, c})) ?
             $signed({2'b00, a}) - $signed({2'b00, c}) :
             $signed({2'b00, c}) - $signed({2'b00, a});
        pc = ($signed(10'({2'b00, a}) + 10'({2'b00, b}) - 10'({1'b0, c, 1'b0})) >= 0) ?
             $signed(10'({2'b00, a}) + 10'({2'b00, b}) - 10'({1'b0, c, 1'b0})) :
             $signed(10'({1'b0, c, 1'b0}) - 10'({2'b00, a}) - 10'({2'b00, b}));

        case (s1_word_reg.filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = avg_sum[8:1];
            FILT_PAETH:
            begin
                if (pa <= pb && pa <= pc)
                begin
                    pred = a;
                end
                else if (pb <= pc)
                begin
                    pred = b;
                end
                else
                begin
                    pred = c;
                end
            end
            default:    pred = 8'h00;
        endcase
        recon = s1_word_reg.data + pred;

        flipped = flip_byte(~recon);
        tmask   = 8'hFF;
        if (s1_word_reg.row_end && (s1_word_reg.tail != 3'd0))
        begin
            tmask = 8'((9'd1 << s1_word_reg.tail) - 9'd1);
        end

        out_word            = '0;
        out_word.bad        = s1_word_reg.bad;
        if (!s1_word_reg.bad)
        begin
            out_word.bitmap     = flipped & tmask;
            out_word.last_row   = s1_word_reg.row_end;
            out_word.last_image = s1_word_reg.image_end;
        end
    end

    assign out_push = fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
            left_reg     <= 8'h00;
            upleft_reg   <= 8'h00;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (load)
            begin
                byp_reg <= byp_next;
            end
            if (wr_mem)
            begin
                left_reg   <= recon;
                upleft_reg <= b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            s1_word_reg <= in_word;
            s1_col_reg  <= in_col;
            rdata_reg   <= row_mem[in_col];
        end
        if (wr_mem)
        begin
            row_mem[s1_col_reg] <= recon;
        end
    end

endmodule

>>> src/png_scanline_unfilter_1bpp_core.sv
// ---------------------------------------------------------------------------
// png_scanline_unfilter_1bpp_core: PNG 1-bit grayscale row reconstruction
// Rebuilds filtered scanlines (none/sub/up/average/Paeth) from an inflated
// byte stream and emits inverted, bit-reversed, tail-masked bitmap words.
// ---------------------------------------------------------------------------
// Usage:
//  - Input queue side: present data_byte/first_of_image with push; a word is
//    taken on any edge with push high and full low. Assert first_of_image on
//    the first byte of each image (it is that image's first filter byte).
//  - Result queue side: while empty is low the oldest result sits on
//    bitmap_byte/last_of_row/last_of_image/bad_filter; pop takes it.
//  - Config channel: cfg_valid/cfg_ready (ready always high), cfg_index 0 is
//    image_width, 1 is image_height. Write only while the block is idle.
//  - Throughput: one input word per cycle while full is low; filter bytes
//    make no result. The combinational filter path (add/Paeth chain) and a
//    row memory that is read and written together, with a write-to-read
//    bypass, set this rate. A taken data byte passes the front queue, then
//    the reconstruction stage, then the result queue that the result side reads.
//  - A filter byte above 4 yields one bad_filter word, then all input is
//    dropped until first_of_image. Bytes after the last row are dropped.
//  - Reset: width and height return to 1, counters clear, queues empty. The
//    row memory is not cleared; the first row never uses it.
//  - A stalled result side backs up through the queues until full rises;
//    nothing is lost. Row memory holds MAX_DIMENSION/8 bytes; a longer row
//    folds its last byte onto entry 0.
// ---------------------------------------------------------------------------
module png_scanline_unfilter_1bpp_core #(
    parameter int MAX_DIMENSION = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // input queue side
    input  logic                              push,
    output logic                              full,
    input  logic [7:0]                        data_byte,
    input  logic                              first_of_image,
    // result queue side
    output logic                              empty,
    input  logic                              pop,
    output logic [7:0]                        bitmap_byte,
    output logic                              last_of_row,
    output logic                              last_of_image,
    output logic                              bad_filter,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [png_unf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [png_unf_pkg::DIM_W-1:0]     cfg_data
);
    import png_unf_pkg::*;

    localparam int ROW_DEPTH     = MAX_DIMENSION / 8;
    localparam int ROW_BYTES_MAX = (MAX_DIMENSION + 7) / 8;
    localparam int COL_W         = (ROW_BYTES_MAX > 1) ? $clog2(ROW_BYTES_MAX) : 1;
    localparam int ADDR_W        = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;
    localparam int MID_W         = $bits(mid_word_t) + ADDR_W;

    logic [DIM_W-1:0]  width_reg, height_reg;

    logic              accept;
    logic              emit;
    mid_word_t         emit_word;
    logic [ADDR_W-1:0] emit_col;

    logic              mid_empty, mid_pop;
    logic [MID_W-1:0]  mid_rd;
    mid_word_t         mid_word;
    logic [ADDR_W-1:0] mid_col;

    logic              res_full, res_push;
    out_word_t         res_word, res_head;

    // config registers: always ready, one write per handshake
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    assign accept = push && !full;

    png_unf_front #(
        .MAX_DIMENSION(MAX_DIMENSION),
        .ROW_DEPTH    (ROW_DEPTH),
        .COL_W        (COL_W),
        .ADDR_W       (ADDR_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (data_byte),
        .first_of_image(first_of_image),
        .image_width   (width_reg),
        .image_height  (height_reg),
        .emit          (emit),
        .emit_word     (emit_word),
        .emit_col      (emit_col)
    );

    // decoupling queue between classifier and reconstruction
    png_unf_fifo #(
        .WIDTH(MID_W),
        .DEPTH(2)
    ) u_mid_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (emit),
        .wr_data({emit_word, emit_col}),
        .full   (full),
        .rd_en  (mid_pop),
        .rd_data(mid_rd),
        .empty  (mid_empty)
    );

    assign mid_word = mid_word_t'(mid_rd[MID_W-1:ADDR_W]);
    assign mid_col  = mid_rd[ADDR_W-1:0];

    png_unf_back #(
        .ROW_DEPTH(ROW_DEPTH),
        .COL_W    (ADDR_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_empty(mid_empty),
        .in_word (mid_word),
        .in_col  (mid_col),
        .in_pop  (mid_pop),
        .out_full(res_full),
        .out_push(res_push),
        .out_word(res_word)
    );

    // result queue: keeps results while the receiver stalls
    png_unf_fifo #(
        .WIDTH($bits(out_word_t)),
        .DEPTH(2)
    ) u_res_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_push),
        .wr_data(res_word),
        .full   (res_full),
        .rd_en  (pop),
        .rd_data(res_head),
        .empty  (empty)
    );

    assign bitmap_byte   = res_head.bitmap;
    assign last_of_row   = res_head.last_row;
    assign last_of_image = res_head.last_image;
    assign bad_filter    = res_head.bad;

endmodule

>>> bench/png_unfilter_checker.sv
// ---------------------------------------------------------------------------
// png_unfilter_checker: scoreboard for the 1 bpp scanline unfilter core
// Watches the input, result and config channels, rebuilds every accepted
// byte in its own row model and compares each popped word in order.
// ---------------------------------------------------------------------------
module png_unfilter_checker #(
    parameter int MAX_DIMENSION = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  logic [7:0]                        data_byte,
    input  logic                              first_of_image,
    input  logic                              empty,
    input  logic                              pop,
    input  logic [7:0]                        bitmap_byte,
    input  logic                              last_of_row,
    input  logic                              last_of_image,
    input  logic                              bad_filter,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [png_unf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [png_unf_pkg::DIM_W-1:0]     cfg_data,
    output int                                fail_count,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import png_unf_pkg::*;

    localparam int ROW_DEPTH = MAX_DIMENSION / 8;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [7:0]       row_mem [ROW_DEPTH];
    logic [7:0]       left_byte;
    logic [7:0]       upper_left_byte;
    int unsigned      col_idx;
    int unsigned      row_idx;
    logic [2:0]       row_filt;
    logic             need_filter;
    logic             stopped;
    out_word_t        bitmap_q [$];
    int               errors = 0;

    function automatic int unsigned dim_clamp(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > MAX_DIMENSION)
        begin
            return MAX_DIMENSION;
        end
        return 32'(v);
    endfunction

    function automatic logic [7:0] paeth_pred(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        int est;
        int da;
        int db;
        int dc;
        est = int'(a) + int'(b) - int'(c);
        da  = est - int'(a);
        db  = est - int'(b);
        dc  = est - int'(c);
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (dc < 0) dc = -dc;
        if (da <= db && da <= dc)
        begin
            return a;
        end
        return (db <= dc) ? b : c;
    endfunction

    function automatic logic [7:0] mirror_byte(input logic [7:0] v);
        return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
    endfunction

    task automatic clear_image();
        left_byte       = '0;
        upper_left_byte = '0;
        col_idx         = 0;
        row_idx         = 0;
        row_filt        = FILT_NONE;
        need_filter     = 1'b1;
        stopped         = 1'b0;
    endtask

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] png unfilter mismatch: %s", $time, msg);
    endtask

    // one accepted byte through the row model; queues the word it makes, if any
    task automatic rebuild_byte(input logic [7:0] b, input logic restart);
        int unsigned width;
        int unsigned height;
        int unsigned bytes_per_row;
        int unsigned tail;
        int unsigned col;
        int          avg;
        logic [7:0]  above;
        logic [7:0]  recon;
        logic [7:0]  pixels;
        logic        row_done;
        out_word_t   w;
        width         = dim_clamp(width_reg);
        height        = dim_clamp(height_reg);
        bytes_per_row = (width + 7) / 8;
        tail          = width % 8;
        w             = '0;
        if (restart)
        begin
            clear_image();
        end
        if (stopped || row_idx >= height)
        begin
            return;
        end
        if (need_filter)
        begin
            if (b > FILT_LAST)
            begin
                stopped = 1'b1;
                w.bad   = 1'b1;
                bitmap_q.push_back(w);
                return;
            end
            row_filt        = b[2:0];
            need_filter     = 1'b0;
            left_byte       = '0;
            upper_left_byte = '0;
            col_idx         = 0;
            return;
        end
        col   = (col_idx >= bytes_per_row) ? bytes_per_row - 1 : col_idx;
        above = (row_idx != 0) ? row_mem[col % ROW_DEPTH] : 8'h00;
        case (row_filt)
            FILT_SUB:   recon = b + left_byte;
            FILT_UP:    recon = b + above;
            FILT_AVG:
            begin
                avg   = (int'(left_byte) + int'(above)) / 2;
                recon = 8'(int'(b) + avg);
            end
            FILT_PAETH: recon = b + paeth_pred(left_byte, above, upper_left_byte);
            default:    recon = b;
        endcase
        row_mem[col % ROW_DEPTH] = recon;
        upper_left_byte          = above;
        left_byte                = recon;
        pixels                   = mirror_byte(~recon);
        row_done                 = (col == bytes_per_row - 1);
        if (row_done)
        begin
            if (tail != 0)
            begin
                pixels = pixels & 8'((1 << tail) - 1);
            end
            row_idx++;
            w.last_image = (row_idx >= height);
            need_filter  = 1'b1;
            col_idx      = 0;
        end
        else
        begin
            col_idx = col + 1;
        end
        w.bitmap   = pixels;
        w.last_row = row_done;
        bitmap_q.push_back(w);
    endtask

    // pops are checked before the same edge's push is modeled: a word taken
    // now can never leave the block at this edge; a register write lands
    // after this edge's byte, as in the block
    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            width_reg  = DIM_W'(1);
            height_reg = DIM_W'(1);
            foreach (row_mem[i])
            begin
                row_mem[i] = '0;
            end
            clear_image();
            bitmap_q.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (bitmap_q.size() == 0)
                begin
                    report_mismatch($sformatf("word %02h/%b%b%b popped with none expected",
                                              bitmap_byte, last_of_row, last_of_image,
                                              bad_filter));
                end
                else
                begin
                    want = bitmap_q.pop_front();
                    if (bitmap_byte !== want.bitmap)
                        report_mismatch($sformatf("bitmap_byte got %02h expected %02h",
                                                  bitmap_byte, want.bitmap));
                    if (last_of_row !== want.last_row)
                        report_mismatch($sformatf("last_of_row got %b expected %b",
                                                  last_of_row, want.last_row));
                    if (last_of_image !== want.last_image)
                        report_mismatch($sformatf("last_of_image got %b expected %b",
                                                  last_of_image, want.last_image));
                    if (bad_filter !== want.bad)
                        report_mismatch($sformatf("bad_filter got %b expected %b",
                                                  bad_filter, want.bad));
                end
            end
            if (push && !full)
            begin
                rebuild_byte(data_byte, first_of_image);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = cfg_data;
            end
        end
        fail_count <= errors;
        pending    <= bitmap_q.size();
    end

endmodule

>>> bench/tb_png_scanline_unfilter_1bpp_core.sv
// ---------------------------------------------------------------------------
// tb_png_scanline_unfilter_1bpp_core: testbench for the 1 bpp unfilter core
// Directed images cover every filter, byte extremes, tail masking, bad filter
// codes and dropped bytes; random phases then sweep image sizes with random
// idling on both queue sides and two long result-side stalls. A checker module
// beside the core predicts and compares every result word.
// ---------------------------------------------------------------------------
module tb_png_scanline_unfilter_1bpp_core;
    timeunit 1ns;
    timeprecision 1ps;

    import png_unf_pkg::*;

    localparam int  HALF_PERIOD  = 4;
    localparam int  RANDOM_ITEMS = 1650;   // random phases run until this many input words are taken
    localparam int  DRAIN_CYCLES = 16;     // no-result bytes still in flight
    localparam int  HOLD_CYCLES  = 400;    // long result-side stall
    localparam int  END_WAIT     = 20000;
    localparam int  TIMEOUT_NS   = 5_000_000;

    logic                 clk            = 1'b0;
    logic                 rst_n          = 1'b0;
    logic                 push           = 1'b0;
    logic                 full;
    logic [7:0]           data_byte      = '0;
    logic                 first_of_image = 1'b0;
    logic                 empty;
    logic                 pop            = 1'b0;
    logic [7:0]           bitmap_byte;
    logic                 last_of_row;
    logic                 last_of_image;
    logic                 bad_filter;
    logic                 cfg_valid      = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [DIM_W-1:0]     cfg_data       = '0;

    int   fail_count;
    int   pending;
    int   words_sent = 0;  // input words taken so far
    int   tx_level   = 0;  // idling intensity per side: 0 none, 1 light, 2 heavy
    int   rx_level   = 0;
    logic hold_rx    = 1'b0;

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    png_scanline_unfilter_1bpp_core i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .first_of_image (first_of_image),
        .empty          (empty),
        .pop            (pop),
        .bitmap_byte    (bitmap_byte),
        .last_of_row    (last_of_row),
        .last_of_image  (last_of_image),
        .bad_filter     (bad_filter),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    png_unfilter_checker i_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .data_byte      (data_byte),
        .first_of_image (first_of_image),
        .empty          (empty),
        .pop            (pop),
        .bitmap_byte    (bitmap_byte),
        .last_of_row    (last_of_row),
        .last_of_image  (last_of_image),
        .bad_filter     (bad_filter),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // per-word wait; level 1 idles now and then, level 2 on most words
    function automatic int idle_gap(input int level);
        if (level == 0)
            return 0;
        if (level == 1 && $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // mostly random bytes, with all-zero / all-one bytes mixed in to hit Paeth ties
    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 3) == 0)
            return {8{1'($urandom_range(0, 1))}};
        return 8'($urandom);
    endfunction

    // effective dimension: 0 counts as 1, oversize counts as the maximum
    function automatic int dim_eff(input int v);
        if (v == 0)
            return 1;
        return (v > 1024) ? 1024 : v;
    endfunction

    // One input word. push stays high across back-to-back words, so it is
    // only lowered when an idle gap is drawn; one NBA per signal per edge.
    task automatic send_word(input logic [7:0] b, input logic restart);
        int gap;
        gap = idle_gap(tx_level);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push           <= 1'b1;
        data_byte      <= b;
        first_of_image <= restart;
        @(posedge clk);
        while (full) @(posedge clk);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait for the block to go idle before a register write. The extra edge
    // lets the checker account for the last word taken; the drain covers
    // filter or dropped bytes that make no result but may still be in flight.
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One image of rb bytes per row and rows_total rows, cut off after
    // row_cap rows. Rarely a bad filter kills it or it stops mid-row, in
    // which case the next image's first byte restarts the block.
    task automatic send_image(input int rb, input int rows_total, input int row_cap);
        int rows;
        int n;
        rows = (rows_total < row_cap) ? rows_total : row_cap;
        for (int r = 0; r < rows; r++)
        begin
            if ($urandom_range(0, 99) < 2)
            begin
                send_word(8'($urandom_range(int'(FILT_LAST) + 1, 255)), r == 0);
                n = $urandom_range(0, 3);
                repeat (n) send_word(rand_byte(), 1'b0);   // dropped while halted
                return;
            end
            send_word(8'($urandom_range(int'(FILT_NONE), int'(FILT_PAETH))), r == 0);
            for (int c = 0; c < rb; c++)
            begin
                if ($urandom_range(0, 299) == 0)
                    return;
                send_word(rand_byte(), 1'b0);
            end
        end
        // bytes past the last row are dropped by the block
        if (rows == rows_total && $urandom_range(0, 3) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_word(rand_byte(), $urandom_range(0, 7) == 0 ? 1'b0 : 1'b0);
        end
    endtask

    // result side: random pop gaps, plus the long hold when requested
    initial
    begin : result_side
        int gap;
        forever
        begin
            gap = idle_gap(rx_level);
            if (gap > 0 || hold_rx)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_rx) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
        end
    end

    // Long stalls on the result side while the sender keeps pushing: the
    // queues back up until full rises and the sender has to wait.
    initial
    begin : result_hold
        wait (words_sent >= 300);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
        wait (words_sent >= 1100);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rx <= 1'b0;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("** png_scanline_unfilter_1bpp_core: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        int phase;
        int w;
        int h;
        int rb;
        int n_img;
        int cap;
        int waited;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed, reset dimensions (1 x 1): one byte rows, 1-bit tail
        send_word(8'(FILT_NONE), 1'b1);
        send_word(8'h00, 1'b0);
        send_word(8'(FILT_PAETH), 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h12, 1'b0);            // after the last row: dropped
        send_word(8'hFF, 1'b1);            // largest bad filter code
        send_word(8'h00, 1'b0);            // dropped while halted
        settle();

        // --- directed, 9 x 5: two bytes per row, every filter in turn
        write_reg(REG_IMAGE_WIDTH, 11'd9);
        write_reg(REG_IMAGE_HEIGHT, 11'd5);
        send_word(8'(FILT_SUB), 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'(FILT_UP), 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'(FILT_AVG), 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(8'(FILT_PAETH), 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'(FILT_NONE), 1'b0);
        send_word(8'hC3, 1'b0);
        send_word(8'h3C, 1'b0);
        send_word(8'(FILT_LAST + 8'd1), 1'b1);   // smallest bad filter code
        settle();

        // --- random phases; extreme dimensions are mixed in early
        phase = 0;
        while (words_sent < RANDOM_ITEMS)
        begin
            case (phase)
                1:       begin w = 1024; h = 2;    end
                3:       begin w = 2047; h = 1;    end   // counts as 1024
                5:       begin w = 0;    h = 0;    end   // both count as 1
                7:       begin w = 8;    h = 2047; end   // tall, never finished
                9:       begin w = 1023; h = 1024; end
                default:
                begin
                    w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 300)
                                                    : $urandom_range(1, 40);
                    h = $urandom_range(1, 6);
                end
            endcase
            write_reg(REG_IMAGE_WIDTH, DIM_W'(w));
            write_reg(REG_IMAGE_HEIGHT, DIM_W'(h));
            tx_level = $urandom_range(0, 2);
            rx_level = $urandom_range(0, 2);
            rb       = (dim_eff(w) + 7) / 8;
            cap      = 300 / (rb + 1);
            if (cap < 1)
                cap = 1;
            n_img = $urandom_range(1, 3);
            repeat (n_img) send_image(rb, dim_eff(h), cap);
            settle();
            phase++;
        end

        // --- wind down: every expected word out, then a short drain
        push <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < END_WAIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("** png_scanline_unfilter_1bpp_core: PASSED **");
        end
        else
        begin
            $display("** png_scanline_unfilter_1bpp_core: FAILED **");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/png_unf_pkg.sv
src/png_unf_fifo.sv
src/png_unf_front.sv
src/png_unf_back.sv
src/png_scanline_unfilter_1bpp_core.sv
bench/png_unfilter_checker.sv
bench/tb_png_scanline_unfilter_1bpp_core.sv
